// ===== hw/rtl/odtm_pkg.sv =====
// Package for the ordered dither block: item types, threshold masks and
// phase constants. No dependencies; used by the interface file and the top level.
package odtm_pkg;

    // Row and column phases count modulo the LCM of the three mask sizes.
    localparam int unsigned PHASE_MOD = 12;
    localparam int unsigned PHASE_W   = 4;

    // Quantizer step for each mask: full scale over the number of mask cells.
    localparam int unsigned DIV_TWO   = 255 / (2 * 2);
    localparam int unsigned DIV_THREE = 255 / (3 * 3);
    localparam int unsigned DIV_FOUR  = 255 / (4 * 4);

    typedef logic [PHASE_W-1:0] t_phase;

    // Input item: one gray pixel with its raster markers.
    typedef struct packed {
        logic [7:0] gray;
        logic       first_of_image;
        logic       last_of_row;
    } t_pixel;

    // Result item: one black/white decision per mask.
    typedef struct packed {
        logic white_two;
        logic white_three;
        logic white_four;
    } t_result;

    // Threshold masks.
    localparam logic [1:0] MASK_TWO [0:1][0:1] = '{
        '{2'd0, 2'd2},
        '{2'd1, 2'd3}
    };
    localparam logic [3:0] MASK_THREE [0:2][0:2] = '{
        '{4'd2, 4'd6, 4'd4},
        '{4'd5, 4'd0, 4'd1},
        '{4'd8, 4'd3, 4'd7}
    };
    localparam logic [3:0] MASK_FOUR [0:3][0:3] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

    // Phase modulo 3, for the 3x3 mask.
    localparam logic [1:0] PHASE_MOD3 [0:PHASE_MOD-1] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
    };

    // gray / step > m holds exactly when gray >= (m + 1) * step.
    // All thresholds stay at or below 252, so nine bits are ample.
    function automatic logic [8:0] threshold(input logic [3:0] m, input int unsigned step);
        logic [8:0] t;
        t = 9'(({5'd0, m} + 9'd1) * 9'(step));
        return t;
    endfunction

    // Advance a phase by one, wrapping at the modulus.
    function automatic t_phase phase_inc(input t_phase p);
        t_phase q;
        q = (p == t_phase'(PHASE_MOD - 1)) ? '0 : p + t_phase'(1);
        return q;
    endfunction

endpackage

// ===== hw/rtl/odtm_stream_if.sv =====
// Valid/ready stream channel carrying one item per handshake.
// Depends on odtm_pkg only through the default payload type, odtm_pkg::t_pixel.
interface odtm_stream_if #(
    parameter type t_payload = odtm_pkg::t_pixel
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ordered_dither_three_masks.sv =====
// Ordered dithering of a gray pixel stream with 2x2, 3x3 and 4x4 masks.
// Depends on odtm_pkg and odtm_stream_if.
//
//   port     dir   payload          meaning
//   i_pix    sink  odtm_pkg::t_pixel  gray pixel, image start, end of row
//   o_bits   src   odtm_pkg::t_result three black/white decisions
//
// One item per cycle sustained while o_bits is not stalled; an accepted item
// passes the input register, then the result register, before its result is
// valid on o_bits. The phase counters and the threshold compares sit between
// the two registers. Synchronous active-low reset empties both stages and
// zeroes the row and column phases. A stall on o_bits freezes both stages;
// i_pix stays ready while the input stage is empty.
module ordered_dither_three_masks (
    input  logic           i_clk,
    input  logic           i_rst_n,
    odtm_stream_if.sink    i_pix,
    odtm_stream_if.source  o_bits
);

    logic                r_in_valid, n_in_valid;
    odtm_pkg::t_pixel    r_in,       n_in;
    logic                r_out_valid, n_out_valid;
    odtm_pkg::t_result   r_out,       n_out;
    odtm_pkg::t_phase    r_col_phase, n_col_phase;
    odtm_pkg::t_phase    r_row_phase, n_row_phase;

    logic                w_advance;
    odtm_pkg::t_phase    w_col;
    odtm_pkg::t_phase    w_row;
    logic [1:0]          w_col3;
    logic [1:0]          w_row3;
    logic [8:0]          w_gray;

    // Both stages move together unless the result is held by the sink.
    assign w_advance   = !r_out_valid || o_bits.ready;
    assign i_pix.ready = !r_in_valid || w_advance;

    // Phases seen by the pixel in the input stage; image start clears them.
    assign w_col  = r_in.first_of_image ? '0 : r_col_phase;
    assign w_row  = r_in.first_of_image ? '0 : r_row_phase;
    assign w_col3 = odtm_pkg::PHASE_MOD3[w_col];
    assign w_row3 = odtm_pkg::PHASE_MOD3[w_row];
    assign w_gray = {1'b0, r_in.gray};

    // Capture a new pixel when the input stage frees up.
    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (i_pix.ready) begin
            n_in_valid = i_pix.valid;
            n_in       = i_pix.payload;
        end
    end

    // Judge the pixel against each mask and advance the phases.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        if (w_advance) begin
            n_out_valid = r_in_valid;
            n_out.white_two = w_gray >= odtm_pkg::threshold(
                {2'b00, odtm_pkg::MASK_TWO[w_row[0]][w_col[0]]}, odtm_pkg::DIV_TWO);
            n_out.white_three = w_gray >= odtm_pkg::threshold(
                odtm_pkg::MASK_THREE[w_row3][w_col3], odtm_pkg::DIV_THREE);
            n_out.white_four = w_gray >= odtm_pkg::threshold(
                odtm_pkg::MASK_FOUR[w_row[1:0]][w_col[1:0]], odtm_pkg::DIV_FOUR);
            if (r_in_valid) begin
                if (r_in.last_of_row) begin
                    n_col_phase = '0;
                    n_row_phase = odtm_pkg::phase_inc(w_row);
                end else begin
                    n_col_phase = odtm_pkg::phase_inc(w_col);
                    n_row_phase = w_row;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col_phase <= '0;
            r_row_phase <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_bits.valid   = r_out_valid;
    assign o_bits.payload = r_out;

`ifndef SYNTHESIS
    // Phases never leave the modulus range.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_phase < odtm_pkg::t_phase'(odtm_pkg::PHASE_MOD))
        && (r_row_phase < odtm_pkg::t_phase'(odtm_pkg::PHASE_MOD)))
        else $error("phase counter out of range");

    // A finished row restarts the column phase.
    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_valid && r_in.last_of_row) |=> (r_col_phase == '0))
        else $error("column phase not cleared at end of row");

    // A pixel leaving the input stage always lands in the result register.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_valid) |=> r_out_valid)
        else $error("item dropped between stages");
`endif

endmodule

// ===== verif/tb_ordered_dither_three_masks.sv =====
`timescale 1ns / 100ps
// Testbench for ordered_dither_three_masks: gray pixels with raster markers go in,
// and each set of three mask decisions is checked against an in-bench predictor.
// Depends on odtm_pkg, odtm_stream_if and the block itself.
module tb_ordered_dither_three_masks;

    // Quantizer steps and threshold masks of the three dither patterns
    localparam int unsigned STEP_TWO   = 255 / 4;
    localparam int unsigned STEP_THREE = 255 / 9;
    localparam int unsigned STEP_FOUR  = 255 / 16;
    localparam int unsigned PHASES     = 12;

    localparam int unsigned BAYER_TWO [0:1][0:1] = '{'{0, 2}, '{1, 3}};
    localparam int unsigned BAYER_THREE [0:2][0:2] = '{
        '{2, 6, 4}, '{5, 0, 1}, '{8, 3, 7}
    };
    localparam int unsigned BAYER_FOUR [0:3][0:3] = '{
        '{0, 8, 2, 10}, '{12, 4, 14, 6}, '{3, 11, 1, 9}, '{15, 7, 13, 5}
    };

    // Row that wraps the column phase, with grays on the quantizer edges
    localparam logic [7:0] RAMP [0:12] = '{
        8'd0, 8'd14, 8'd15, 8'd27, 8'd28, 8'd62, 8'd63,
        8'd64, 8'd126, 8'd189, 8'd252, 8'd254, 8'd255
    };

    // Grays for the single-pixel rows that walk the row phase
    localparam logic [7:0] ROW_WALK [0:6] = '{
        8'd200, 8'd100, 8'd45, 8'd30, 8'd90, 8'd160, 8'd220
    };

    localparam int unsigned N_RANDOM     = 460;
    localparam int unsigned N_PRESSURE   = 40;
    localparam int unsigned LONG_HOLD    = 200;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;

    odtm_stream_if #(.t_payload(odtm_pkg::t_pixel))  pix_if ();
    odtm_stream_if #(.t_payload(odtm_pkg::t_result)) bits_if ();

    ordered_dither_three_masks uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_bits  (bits_if)
    );

    odtm_pkg::t_pixel  pixel_feed [$];
    odtm_pkg::t_result dither_q [$];
    odtm_pkg::t_phase  col_ph;
    odtm_pkg::t_phase  row_ph;
    odtm_pkg::t_result want;
    int unsigned src_gap;
    bit          src_burst;
    int unsigned snk_wait;
    bit          snk_burst;
    int unsigned hold_left;
    int unsigned n_queued;
    int unsigned n_accepted;
    int unsigned n_checked;
    int unsigned n_fail;
    int unsigned n_images;
    int unsigned widest_row;
    int unsigned tallest_image;

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Judge one pixel against the three masks and advance the raster phases
    function automatic odtm_pkg::t_result dither_pixel(input odtm_pkg::t_pixel p);
        odtm_pkg::t_result res;
        int unsigned r;
        int unsigned c;
        int unsigned g;
        if (p.first_of_image) begin
            col_ph = '0;
            row_ph = '0;
        end
        r = int'(row_ph);
        c = int'(col_ph);
        g = int'(p.gray);
        res.white_two   = (g / STEP_TWO) > BAYER_TWO[r % 2][c % 2];
        res.white_three = (g / STEP_THREE) > BAYER_THREE[r % 3][c % 3];
        res.white_four  = (g / STEP_FOUR) > BAYER_FOUR[r % 4][c % 4];
        if (p.last_of_row) begin
            col_ph = '0;
            row_ph = odtm_pkg::t_phase'((r + 1) % PHASES);
        end else begin
            col_ph = odtm_pkg::t_phase'((c + 1) % PHASES);
        end
        return res;
    endfunction

    // Gray level biased toward the extremes and the quantizer edges
    function automatic logic [7:0] pick_gray();
        int unsigned s;
        int unsigned v;
        case ($urandom_range(0, 3))
            0: begin
                v = $urandom_range(0, 1) ? 255 : 0;
            end
            1: begin
                case ($urandom_range(0, 2))
                    0:       s = STEP_TWO;
                    1:       s = STEP_THREE;
                    default: s = STEP_FOUR;
                endcase
                v = s * $urandom_range(1, 255 / s) - $urandom_range(0, 1);
            end
            default: begin
                v = $urandom_range(0, 255);
            end
        endcase
        return v[7:0];
    endfunction

    task automatic queue_pixel(input logic [7:0] g, input logic first, input logic last);
        odtm_pkg::t_pixel p;
        p.gray           = g;
        p.first_of_image = first;
        p.last_of_row    = last;
        pixel_feed.push_back(p);
        n_queued++;
    endtask

    // Hold the sender until every queued pixel has come back as a result
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_feed.size() != 0 || pix_if.valid || dither_q.size() != 0);
    endtask

    // Offer pending pixels with random gaps; predict each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            src_gap = 0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (pix_if.valid) begin
                dither_q.push_back(dither_pixel(pix_if.payload));
                n_accepted++;
            end
            if (src_gap != 0) begin
                src_gap--;
                pix_if.valid <= 1'b0;
            end else if (pixel_feed.size() != 0) begin
                pix_if.payload <= pixel_feed.pop_front();
                pix_if.valid   <= 1'b1;
                if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
                src_gap = src_burst ? 0 : $urandom_range(0, 16);
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Count down the long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // Accept results with random stalls and compare against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bits_if.ready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (bits_if.valid && bits_if.ready) begin
                if (dither_q.size() == 0) begin
                    $error("result %b with no pixel pending", bits_if.payload);
                    n_fail++;
                end else begin
                    want = dither_q.pop_front();
                    n_checked++;
                    if (bits_if.payload.white_two !== want.white_two) begin
                        $error("white_two: expected %0b, actual %0b",
                               want.white_two, bits_if.payload.white_two);
                        n_fail++;
                    end
                    if (bits_if.payload.white_three !== want.white_three) begin
                        $error("white_three: expected %0b, actual %0b",
                               want.white_three, bits_if.payload.white_three);
                        n_fail++;
                    end
                    if (bits_if.payload.white_four !== want.white_four) begin
                        $error("white_four: expected %0b, actual %0b",
                               want.white_four, bits_if.payload.white_four);
                        n_fail++;
                    end
                end
                if ($urandom_range(0, 31) == 0) snk_burst = !snk_burst;
                snk_wait = snk_burst ? 0 : $urandom_range(0, 16);
            end else if (snk_wait != 0) begin
                snk_wait--;
            end
            bits_if.ready <= (snk_wait == 0) && (hold_left == 0);
        end
    end

    // Stimulus: directed pixels, a backpressure phase, then random images
    initial begin
        int unsigned rows;
        int unsigned width;
        int unsigned n_target;
        bit          with_start;
        pix_if.valid   = 1'b0;
        pix_if.payload = '0;
        bits_if.ready  = 1'b0;
        i_rst_n        = 1'b0;
        hold_left      = 0;
        col_ph         = '0;
        row_ph         = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phases carry on from reset without an image start
        queue_pixel(8'd255, 1'b0, 1'b0);
        queue_pixel(8'd0, 1'b0, 1'b1);
        // Image start and row end on one pixel
        queue_pixel(8'd128, 1'b1, 1'b1);
        // Row long enough to wrap the column phase
        for (int i = 0; i < 13; i++) queue_pixel(RAMP[i], i == 0, i == 12);
        // Single-pixel rows walk the row phase
        for (int i = 0; i < 7; i++) queue_pixel(ROW_WALK[i], 1'b0, 1'b1);
        wait_drained();

        // Stall the output long enough for the block to back up its input
        hold_left = LONG_HOLD;
        for (int i = 0; i < N_PRESSURE; i++)
            queue_pixel(pick_gray(), i == 0, (i % 7) == 6);
        wait_drained();

        // Random images, with some unframed noise and missing image starts
        n_target = n_queued + N_RANDOM;
        while (n_queued < n_target) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 12))
                    queue_pixel(pick_gray(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
            end else begin
                rows = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 16)
                                                   : $urandom_range(1, 12);
                with_start = ($urandom_range(0, 7) != 0);
                if (rows > tallest_image) tallest_image = rows;
                n_images++;
                for (int r = 0; r < rows; r++) begin
                    width = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(1, 8);
                    if (width > widest_row) widest_row = width;
                    for (int c = 0; c < width; c++)
                        queue_pixel(pick_gray(), with_start && r == 0 && c == 0,
                                    c == width - 1);
                end
                if ($urandom_range(0, 3) == 0) wait_drained();
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d pixels (%0d results checked) over %0d random images,",
                 n_accepted, n_checked, n_images);
        $display("rows up to %0d pixels wide, images up to %0d rows tall.",
                 widest_row, tallest_image);
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
